// ===== rtl/coplanar_force_decompose_assert.svh =====
// assertion macros used by the checker file cfd_checker.sv
`ifndef COPLANAR_FORCE_DECOMPOSE_ASSERT_SVH
`define COPLANAR_FORCE_DECOMPOSE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfd_pkg.sv =====
// types and constants for the coplanar force decomposition block
`default_nettype none

package cfd_pkg;

    typedef struct packed {
        logic signed [31:0] magnitude;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } cfd_req_t;

    typedef struct packed {
        logic signed [31:0] part_first;
        logic signed [31:0] part_second;
        logic [1:0]         status;
    } cfd_res_t;

    // per-request side data carried down the pipeline
    typedef struct packed {
        logic signed [31:0] f;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic               s1_zero;
        logic               s2_zero;
        logic               dir_neg;
    } cfd_ctl_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 33;

    localparam logic signed [35:0] ONE_Q30  = 36'sd1 << 30;
    localparam logic [61:0]        ONE_Q60  = 62'd1 << 60;
    localparam logic signed [31:0] I32_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] I32_MIN  = 32'sh80000000;

endpackage

`default_nettype wire

// ===== rtl/coplanar_force_decompose.sv =====
// coplanar force decomposition: fully pipelined top level
//
//  channel | signals                      | dir | payload
//  --------+------------------------------+-----+-------------------------------
//  request | req_valid req_stall req_data | in  | magnitude, target, first, second
//  result  | res_valid res_stall res_data | out | part_first, part_second, status
//
// one request can enter every cycle while req_stall is low; results leave in the order their requests were taken
// the pipe depth is mostly the 31-step square-root pipe and the 33-step quotient pipe
// reset clears every valid bit, the output flag and the skid flag; payload registers hold junk
// a stalled result is parked in a skid register; the pipe then freezes as a whole
// req_stall comes straight from the skid valid flop
`default_nettype none

module coplanar_force_decompose
    import cfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire cfd_req_t req_data,
    output logic          res_valid,
    input  wire logic     res_stall,
    output cfd_res_t      res_data
);

    // global pipe advance: stops only when the skid register is full
    logic en;

    // ------------------------------------------------------------------
    // stage 1: all products of the dot and cross products
    // ------------------------------------------------------------------
    logic signed [31:0] uf [3];
    logic signed [31:0] ua [3];
    logic signed [31:0] ub [3];

    assign uf[0] = req_data.target_x;
    assign uf[1] = req_data.target_y;
    assign uf[2] = req_data.target_z;
    assign ua[0] = req_data.first_x;
    assign ua[1] = req_data.first_y;
    assign ua[2] = req_data.first_z;
    assign ub[0] = req_data.second_x;
    assign ub[1] = req_data.second_y;
    assign ub[2] = req_data.second_z;

    logic               v1_reg;
    logic signed [31:0] f1_reg;
    logic signed [63:0] dot1_reg [3];
    logic signed [63:0] dot2_reg [3];
    logic signed [63:0] cr1_reg  [6];
    logic signed [63:0] cr2_reg  [6];

    // cross product term k is a[k+1]*b[k+2] - a[k+2]*b[k+1], indexes mod 3
    for (genvar k = 0; k < 3; k++) begin : g_mul
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dot1_reg[k]       <= 64'(ua[k]) * 64'(uf[k]);
                dot2_reg[k]       <= 64'(ub[k]) * 64'(uf[k]);
                cr1_reg[2*k]      <= 64'(ua[K1]) * 64'(uf[K2]);
                cr1_reg[2*k + 1]  <= 64'(ua[K2]) * 64'(uf[K1]);
                cr2_reg[2*k]      <= 64'(ub[K1]) * 64'(uf[K2]);
                cr2_reg[2*k + 1]  <= 64'(ub[K2]) * 64'(uf[K1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= req_data.magnitude;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cosines with clamp, cross products
    // ------------------------------------------------------------------
    logic               v2_reg;
    cfd_ctl_t           ctl2_reg;
    cfd_ctl_t           ctl2_next;
    logic signed [31:0] a1_reg  [3];
    logic signed [31:0] a2_reg  [3];
    logic signed [31:0] a1_next [3];
    logic signed [31:0] a2_next [3];
    logic signed [35:0] c1_raw;
    logic signed [35:0] c2_raw;

    always_comb
    begin
        // floor shift of each product, then the sum
        c1_raw = 36'(dot1_reg[0] >>> 30) + 36'(dot1_reg[1] >>> 30) + 36'(dot1_reg[2] >>> 30);
        c2_raw = 36'(dot2_reg[0] >>> 30) + 36'(dot2_reg[1] >>> 30) + 36'(dot2_reg[2] >>> 30);
        ctl2_next         = '0;
        ctl2_next.f       = f1_reg;
        ctl2_next.dir_neg = 1'b0;
        // at or past unit length the cosine pins to plus or minus one and the sine is zero
        if (c1_raw >= ONE_Q30)
        begin
            ctl2_next.c1      = 32'(ONE_Q30);
            ctl2_next.s1_zero = 1'b1;
        end
        else if (c1_raw <= -ONE_Q30)
        begin
            ctl2_next.c1      = 32'(-ONE_Q30);
            ctl2_next.s1_zero = 1'b1;
        end
        else
        begin
            ctl2_next.c1      = c1_raw[31:0];
            ctl2_next.s1_zero = 1'b0;
        end
        if (c2_raw >= ONE_Q30)
        begin
            ctl2_next.c2      = 32'(ONE_Q30);
            ctl2_next.s2_zero = 1'b1;
        end
        else if (c2_raw <= -ONE_Q30)
        begin
            ctl2_next.c2      = 32'(-ONE_Q30);
            ctl2_next.s2_zero = 1'b1;
        end
        else
        begin
            ctl2_next.c2      = c2_raw[31:0];
            ctl2_next.s2_zero = 1'b0;
        end
        for (int k = 0; k < 3; k++)
        begin
            a1_next[k] = 32'(cr1_reg[2*k] >>> 33) - 32'(cr1_reg[2*k + 1] >>> 33);
            a2_next[k] = 32'(cr2_reg[2*k] >>> 33) - 32'(cr2_reg[2*k + 1] >>> 33);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl2_reg <= ctl2_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: cosine squares and the cross-product dot terms
    // ------------------------------------------------------------------
    logic               v3_reg;
    cfd_ctl_t           ctl3_reg;
    logic signed [63:0] csq1_reg;
    logic signed [63:0] csq2_reg;
    logic signed [63:0] dp_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl3_reg <= ctl2_reg;
            csq1_reg <= 64'(ctl2_reg.c1) * 64'(ctl2_reg.c1);
            csq2_reg <= 64'(ctl2_reg.c2) * 64'(ctl2_reg.c2);
            for (int k = 0; k < 3; k++)
            begin
                dp_reg[k] <= 64'(a1_reg[k]) * 64'(a2_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4 and square-root pipe: one root bit per stage
    // ------------------------------------------------------------------
    logic               sq_valid_reg [SQ_STEPS + 1];
    cfd_ctl_t           sq_ctl_reg   [SQ_STEPS + 1];
    logic [61:0]        sq_rem_reg   [2][SQ_STEPS + 1];
    logic [30:0]        sq_root_reg  [2][SQ_STEPS + 1];
    logic signed [63:0] dir_sum;
    cfd_ctl_t           ctl4_next;

    always_comb
    begin
        dir_sum           = dp_reg[0] + dp_reg[1] + dp_reg[2];
        ctl4_next         = ctl3_reg;
        ctl4_next.dir_neg = dir_sum[63];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ctl_reg[0]     <= ctl4_next;
            // a pinned cosine takes a zero radicand, so its sine comes out zero
            sq_rem_reg[0][0]  <= ctl3_reg.s1_zero ? '0 : ONE_Q60 - 62'(csq1_reg);
            sq_rem_reg[1][0]  <= ctl3_reg.s2_zero ? '0 : ONE_Q60 - 62'(csq2_reg);
            sq_root_reg[0][0] <= '0;
            sq_root_reg[1][0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - j;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [61:0] trial;
            logic        take;
            // (root + 2^B)^2 - root^2
            assign trial = (62'(sq_root_reg[l][j]) << (B + 1)) + (62'd1 << (2 * B));
            assign take  = sq_rem_reg[l][j] >= trial;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[l][j + 1]  <= take ? sq_rem_reg[l][j] - trial : sq_rem_reg[l][j];
                    sq_root_reg[l][j + 1] <= sq_root_reg[l][j] | (take ? 31'd1 << B : 31'd0);
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_ctl_reg[j + 1] <= sq_ctl_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // denominator products
    // ------------------------------------------------------------------
    logic               d1_valid_reg;
    cfd_ctl_t           d1_ctl_reg;
    logic [30:0]        d1_s1_reg;
    logic [30:0]        d1_s2_reg;
    logic signed [63:0] d1_pa_reg;
    logic signed [63:0] d1_pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_ctl_reg <= sq_ctl_reg[SQ_STEPS];
            d1_s1_reg  <= sq_root_reg[0][SQ_STEPS];
            d1_s2_reg  <= sq_root_reg[1][SQ_STEPS];
            d1_pa_reg  <= 64'(sq_ctl_reg[SQ_STEPS].c1) * 64'(sq_root_reg[1][SQ_STEPS]);
            d1_pb_reg  <= 64'(sq_ctl_reg[SQ_STEPS].c2) * 64'(sq_root_reg[0][SQ_STEPS]);
        end
    end

    // ------------------------------------------------------------------
    // denominator sum, numerators |f|*s
    // ------------------------------------------------------------------
    logic               d2_valid_reg;
    cfd_ctl_t           d2_ctl_reg;
    logic signed [63:0] d2_d_reg;
    logic [61:0]        d2_pm1_reg;
    logic [61:0]        d2_pm2_reg;
    logic [31:0]        fmag;

    assign fmag = d1_ctl_reg.f[31] ? 32'(-d1_ctl_reg.f) : 32'(d1_ctl_reg.f);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_ctl_reg <= d1_ctl_reg;
            // between rule adds the terms, outside rule subtracts
            d2_d_reg   <= d1_ctl_reg.dir_neg ? d1_pa_reg + d1_pb_reg : d1_pa_reg - d1_pb_reg;
            d2_pm1_reg <= 62'(64'(fmag) * 64'(d1_s2_reg));
            d2_pm2_reg <= 62'(64'(fmag) * 64'(d1_s1_reg));
        end
    end

    // ------------------------------------------------------------------
    // denominator magnitude and quotient signs
    // ------------------------------------------------------------------
    logic        d3_valid_reg;
    cfd_ctl_t    d3_ctl_reg;
    logic [61:0] d3_dm_reg;
    logic        d3_dz_reg;
    logic [1:0]  d3_neg_reg;
    logic [61:0] d3_pm_reg [2];
    logic        sign_q;

    assign sign_q = d2_ctl_reg.f[31] != d2_d_reg[63];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_ctl_reg    <= d2_ctl_reg;
            d3_dm_reg     <= d2_d_reg[63] ? 62'(-d2_d_reg) : 62'(d2_d_reg);
            d3_dz_reg     <= d2_d_reg == '0;
            d3_neg_reg[0] <= sign_q;
            d3_neg_reg[1] <= d2_ctl_reg.dir_neg ? sign_q : !sign_q;
            d3_pm_reg[0]  <= d2_pm1_reg;
            d3_pm_reg[1]  <= d2_pm2_reg;
        end
    end

    // ------------------------------------------------------------------
    // quotient pipe: overflow check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic        dv_valid_reg [DIV_STEPS + 1];
    cfd_ctl_t    dv_ctl_reg   [DIV_STEPS + 1];
    logic [61:0] dv_dm_reg    [DIV_STEPS + 1];
    logic        dv_dz_reg    [DIV_STEPS + 1];
    logic [1:0]  dv_neg_reg   [DIV_STEPS + 1];
    logic [61:0] dv_rem_reg   [2][DIV_STEPS + 1];
    logic [32:0] dv_q_reg     [2][DIV_STEPS + 1];
    logic [2:0]  dv_plo_reg   [2][DIV_STEPS + 1];
    logic        dv_ovf_reg   [2][DIV_STEPS + 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ctl_reg[0] <= d3_ctl_reg;
            dv_dm_reg[0]  <= d3_dm_reg;
            dv_dz_reg[0]  <= d3_dz_reg;
            dv_neg_reg[0] <= d3_neg_reg;
            for (int l = 0; l < 2; l++)
            begin
                // quotient of 2^33 or more saturates anyway
                dv_ovf_reg[l][0] <= 62'(d3_pm_reg[l][61:3]) >= d3_dm_reg;
                dv_rem_reg[l][0] <= 62'(d3_pm_reg[l][61:3]);
                dv_plo_reg[l][0] <= d3_pm_reg[l][2:0];
                dv_q_reg[l][0]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic        nbit;
            logic [62:0] shifted;
            logic        take;
            // numerator is p * 2^30: its bits 32..30 are the low bits of p
            if (B >= 30) begin : g_hi
                assign nbit = dv_plo_reg[l][j][B - 30];
            end
            else begin : g_lo
                assign nbit = 1'b0;
            end
            assign shifted = {dv_rem_reg[l][j], nbit};
            assign take    = shifted >= {1'b0, dv_dm_reg[j]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[l][j + 1] <= take ? 62'(shifted - {1'b0, dv_dm_reg[j]})
                                                 : 62'(shifted);
                    dv_q_reg[l][j + 1]   <= {dv_q_reg[l][j][31:0], take};
                    dv_plo_reg[l][j + 1] <= dv_plo_reg[l][j];
                    dv_ovf_reg[l][j + 1] <= dv_ovf_reg[l][j];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctl_reg[j + 1] <= dv_ctl_reg[j];
                dv_dm_reg[j + 1]  <= dv_dm_reg[j];
                dv_dz_reg[j + 1]  <= dv_dz_reg[j];
                dv_neg_reg[j + 1] <= dv_neg_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // result selection
    // ------------------------------------------------------------------
    // {saturated, value} of a signed quotient with magnitude q
    function automatic logic [32:0] quot_fix(input logic ovf, input logic [32:0] q,
                                             input logic neg);
        logic        big;
        logic [32:0] nq;
        big = ovf || (neg ? (q > 33'h080000000) : (q >= 33'h080000000));
        nq  = -q;
        if (big)
        begin
            return {1'b1, neg ? I32_MIN : I32_MAX};
        end
        return {1'b0, neg ? nq[31:0] : q[31:0]};
    endfunction

    // {saturated, value} of +f or -f
    function automatic logic [32:0] pass_f(input logic signed [31:0] f, input logic pos);
        if (pos)
        begin
            return {1'b0, f};
        end
        if (f == I32_MIN)
        begin
            return {1'b1, I32_MAX};
        end
        return {1'b0, 32'(-f)};
    endfunction

    cfd_ctl_t    fin_ctl;
    logic [32:0] fin_q1;
    logic [32:0] fin_q2;
    logic [32:0] fin_pf;
    logic        fin_fail;
    logic        fin_sat;
    cfd_res_t    res_next;

    assign fin_ctl = dv_ctl_reg[DIV_STEPS];

    always_comb
    begin
        fin_q1   = quot_fix(dv_ovf_reg[0][DIV_STEPS], dv_q_reg[0][DIV_STEPS],
                            dv_neg_reg[DIV_STEPS][0]);
        fin_q2   = quot_fix(dv_ovf_reg[1][DIV_STEPS], dv_q_reg[1][DIV_STEPS],
                            dv_neg_reg[DIV_STEPS][1]);
        fin_pf   = '0;
        fin_fail = 1'b0;
        fin_sat  = 1'b0;
        res_next = '0;
        if (fin_ctl.c1 == '0 && fin_ctl.c2 == '0)
        begin
            // both directions normal to the target
            fin_fail = fin_ctl.f != '0;
        end
        else if (fin_ctl.s1_zero)
        begin
            // first direction parallel to the target
            fin_pf               = pass_f(fin_ctl.f, fin_ctl.c1 > 0);
            res_next.part_first  = fin_pf[31:0];
            fin_sat              = fin_pf[32];
        end
        else if (fin_ctl.s2_zero)
        begin
            fin_pf               = pass_f(fin_ctl.f, fin_ctl.c2 > 0);
            res_next.part_second = fin_pf[31:0];
            fin_sat              = fin_pf[32];
        end
        else if (dv_dz_reg[DIV_STEPS])
        begin
            fin_fail = 1'b1;
        end
        else
        begin
            res_next.part_first  = fin_q1[31:0];
            res_next.part_second = fin_q2[31:0];
            fin_sat              = fin_q1[32] || fin_q2[32];
        end
        if (fin_fail)
        begin
            res_next.status = STATUS_FAIL;
        end
        else if (fin_sat)
        begin
            res_next.status = STATUS_SAT;
        end
        else
        begin
            res_next.status = STATUS_OK;
        end
    end

    // ------------------------------------------------------------------
    // valid bits: all move together on en
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            for (int j = 0; j <= SQ_STEPS; j++)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg          <= req_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            sq_valid_reg[0] <= v3_reg;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_valid_reg[j + 1] <= sq_valid_reg[j];
            end
            d1_valid_reg    <= sq_valid_reg[SQ_STEPS];
            d2_valid_reg    <= d1_valid_reg;
            d3_valid_reg    <= d2_valid_reg;
            dv_valid_reg[0] <= d3_valid_reg;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_valid_reg[j + 1] <= dv_valid_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    logic     out_valid_reg;
    logic     skid_valid_reg;
    cfd_res_t out_data_reg;
    cfd_res_t skid_data_reg;
    logic     out_free;
    logic     push;

    assign en        = !skid_valid_reg;
    assign push      = en && dv_valid_reg[DIV_STEPS];
    assign out_free  = !out_valid_reg || !res_stall;
    assign req_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // the skid drains first; the pipe is frozen while it is full
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end
        else if (push)
        begin
            skid_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfd_checker.sv =====
// port-level checker for the coplanar force decomposition block, with its bind
`default_nettype none

`include "coplanar_force_decompose_assert.svh"

module cfd_checker
    import cfd_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_stall,
    input wire cfd_req_t req_data,
    input wire logic     res_valid,
    input wire logic     res_stall,
    input wire cfd_res_t res_data
);

    // a failed decomposition carries zero parts
    `CFD_ASSERT_NOW(a_fail_zero, res_valid && res_data.status == STATUS_FAIL, res_data.part_first == '0 && res_data.part_second == '0, "failed result with nonzero part")

    // a stalled result stays put
    `CFD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "stalled result changed")

    // request stall only starts after the result side stalled
    `CFD_ASSERT_NOW(a_stall_cause, $rose(req_stall), $past(res_valid && res_stall), "request stall without result stall")

    // while the skid holds a result the output register is full too
    `CFD_ASSERT_NOW(a_stall_full, req_stall, res_valid, "request stall with empty output")

endmodule

bind coplanar_force_decompose cfd_checker u_cfd_checker (.*);

`default_nettype wire
